// ===== rtl/rpw_pkg.sv =====
// Package: types, codes and saturating arithmetic of the rectangle physics world step core.
`timescale 1ns / 1ps
package rpw_pkg;

  localparam int MaxBodiesDef = 64;

  localparam logic [1:0] KindAdd   = 2'd0;
  localparam logic [1:0] KindForce = 2'd1;
  localparam logic [1:0] KindStep  = 2'd2;

  localparam logic [2:0] StAdded = 3'd0;
  localparam logic [2:0] StFull  = 3'd1;
  localparam logic [2:0] StForce = 3'd2;
  localparam logic [2:0] StBad   = 3'd3;
  localparam logic [2:0] StPos   = 3'd4;
  localparam logic [2:0] StEmpty = 3'd5;

  localparam logic [1:0] RegGravX = 2'd0;
  localparam logic [1:0] RegGravY = 2'd1;
  localparam logic [1:0] RegColl  = 2'd2;

  localparam logic signed [31:0] GravYReset = 32'sd642908;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         body_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [31:0]        density;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic [31:0]        delta_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         result_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [31:0]        mass;
  } body_t;

  typedef enum logic [4:0] {
    S_IDLE, S_F_RD, S_F_MOD, S_G_MUL, S_G_SAT, S_EMPTY,
    S_B_RD, S_B_MUL, S_B_V, S_B_P, S_B_COL, S_B_CMUL, S_B_DSTART, S_B_DWAIT,
    S_B_APPLY, S_B_WB, S_B_LAST, S_E_RD, S_E_OUT
  } state_e;

  // Q16.16 product: floor shift by 16, saturate to signed 32 bits
  function automatic logic signed [31:0] sat_mul(input logic signed [64:0] p);
    logic signed [48:0] s;
    s = 49'(p >>> 16);
    if (s > 49'sd2147483647) return 32'sh7fffffff;
    else if (s < -49'sd2147483648) return 32'sh80000000;
    else return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [33:0] b);
    logic signed [34:0] s;
    s = 35'(a) + 35'(b);
    if (s > 35'sd2147483647) return 32'sh7fffffff;
    else if (s < -35'sd2147483648) return 32'sh80000000;
    else return s[31:0];
  endfunction

endpackage

// ===== rtl/rpw_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 33-bit divisor.
`timescale 1ns / 1ps
module rpw_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic [63:0] quotient_o,
  output logic        done_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [33:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [32:0] den_q, den_d;
  logic [33:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    trial  = {rem_q[32:0], quo_q[63]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== rtl/rect_physics_world_step_core.sv =====
// Top level: body table in one memory, sequenced read-modify-write step walk.
//
//  channel  | direction | handshake              | payload
//  in       | input     | in_valid_i / in_stall_o   | rpw_pkg::in_item_t
//  out      | output    | out_valid_o / out_stall_i | rpw_pkg::out_item_t
//  apb      | input     | psel, penable, pready     | paddr, pwdata, prdata
//
// A step scales gravity by the step time, then per body reads it, updates velocity and
// position and, with collisions on, checks it against its predecessor; an overlap is
// split in halves when both densities are zero, else by mass with the divider pair.
// Then one position result is reported per body.
// Reset clears the body count and sets the registers to their defaults; the table needs no clearing.
// A stalled output holds the sequencer in the states that load a result; no input is taken until it resumes.
`timescale 1ns / 1ps
module rect_physics_world_step_core #(
  parameter int MaxBodies = rpw_pkg::MaxBodiesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rpw_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rpw_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = (MaxBodies > 1) ? $clog2(MaxBodies) : 1;
  localparam int CW = $clog2(MaxBodies + 1);

  rpw_pkg::state_e state_q, state_d;

  logic signed [31:0] grav_x_q, grav_y_q;
  logic               coll_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic               out_valid_q;
  rpw_pkg::out_item_t out_q;
  logic               out_load;
  rpw_pkg::out_item_t out_nxt;

  rpw_pkg::body_t body_mem_q [MaxBodies];
  rpw_pkg::body_t rdata_q;
  logic           we;
  logic [CW-1:0]  wa;
  rpw_pkg::body_t wd;

  logic signed [31:0] fx_q, fy_q, gx_q, gy_q;
  logic [31:0]        dt_q;
  logic signed [64:0] prod_x_q, prod_y_q, prod_x_d, prod_y_d;
  rpw_pkg::body_t     cur_q, prev_q;

  logic               above_q, sumz_q;
  logic [31:0]        o_q;
  logic [63:0]        od1_q, od2_q;
  logic [32:0]        sum_q;
  logic [63:0]        q1, q2;
  logic               done1, done2;
  logic               div_start;

  logic               out_free, acc;
  logic signed [35:0] x1, y1, x2, y2, w1, h1, w2, h2, o_w;
  logic               hit_w;
  logic [31:0]        s1, s2;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == rpw_pkg::S_IDLE && out_free);
  assign acc = in_valid_i && !in_stall_o;

  // APB
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      rpw_pkg::RegGravX: prdata = grav_x_q;
      rpw_pkg::RegGravY: prdata = grav_y_q;
      rpw_pkg::RegColl:  prdata = {31'd0, coll_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_x_q <= '0;
      grav_y_q <= rpw_pkg::GravYReset;
      coll_q   <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        rpw_pkg::RegGravX: grav_x_q <= pwdata;
        rpw_pkg::RegGravY: grav_y_q <= pwdata;
        rpw_pkg::RegColl:  coll_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // overlap test, body i against its predecessor
  always_comb begin
    x1 = 36'(cur_q.x);
    y1 = 36'(cur_q.y);
    x2 = 36'(prev_q.x);
    y2 = 36'(prev_q.y);
    w1 = $signed({4'd0, cur_q.w, 16'd0});
    h1 = $signed({4'd0, cur_q.h, 16'd0});
    w2 = $signed({4'd0, prev_q.w, 16'd0});
    h2 = $signed({4'd0, prev_q.h, 16'd0});
    hit_w = (x1 < x2 + w2) && (x1 + w1 > x2) && (y1 < y2 + h2) && (y1 + h1 > y2)
            && (y1 != y2);
    o_w = (y1 < y2) ? (y1 + h1 - y2) : (y2 + h2 - y1);
  end

  assign s1 = sumz_q ? {1'b0, o_q[31:1]} : q1[31:0];
  assign s2 = sumz_q ? {1'b0, o_q[31:1]} : q2[31:0];
  assign div_start = (state_q == rpw_pkg::S_B_DSTART);

  rpw_div u_div1 (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(od1_q), .divisor_i(sum_q),
    .quotient_o(q1), .done_o(done1)
  );
  rpw_div u_div2 (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(od2_q), .divisor_i(sum_q),
    .quotient_o(q2), .done_o(done2)
  );

  // shared lane multipliers: gravity * dt, then g * density
  always_comb begin
    if (state_q == rpw_pkg::S_G_MUL) begin
      prod_x_d = 65'(grav_x_q) * $signed({33'd0, dt_q});
      prod_y_d = 65'(grav_y_q) * $signed({33'd0, dt_q});
    end else begin
      prod_x_d = 65'(gx_q) * $signed({33'd0, rdata_q.mass});
      prod_y_d = 65'(gy_q) * $signed({33'd0, rdata_q.mass});
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    we       = 1'b0;
    wa       = idx_q;
    wd       = rdata_q;
    out_load = 1'b0;
    out_nxt  = '0;
    case (state_q)
      rpw_pkg::S_IDLE: begin
        if (acc) begin
          case (in_data_i.kind)
            rpw_pkg::KindAdd: begin
              out_load = 1'b1;
              out_nxt.last = 1'b1;
              if (count_q == CW'(MaxBodies)) begin
                out_nxt.status = rpw_pkg::StFull;
              end else begin
                we = 1'b1;
                wa = count_q;
                wd = '{x: in_data_i.pos_x, y: in_data_i.pos_y, vx: '0, vy: '0,
                       w: in_data_i.width, h: in_data_i.height,
                       mass: in_data_i.density};
                count_d = count_q + CW'(1);
                out_nxt.status = rpw_pkg::StAdded;
                out_nxt.result_index = 6'(count_q);
              end
            end
            rpw_pkg::KindForce: begin
              if (8'(in_data_i.body_index) >= 8'(count_q)) begin
                out_load = 1'b1;
                out_nxt.status = rpw_pkg::StBad;
                out_nxt.result_index = in_data_i.body_index;
                out_nxt.last = 1'b1;
              end else begin
                idx_d = CW'(in_data_i.body_index);
                state_d = rpw_pkg::S_F_RD;
              end
            end
            rpw_pkg::KindStep: state_d = rpw_pkg::S_G_MUL;
            default: ;
          endcase
        end
      end
      rpw_pkg::S_F_RD: state_d = rpw_pkg::S_F_MOD;
      rpw_pkg::S_F_MOD: begin
        if (out_free) begin
          we = 1'b1;
          wd.vx = rpw_pkg::sat_add(rdata_q.vx, 34'(fx_q));
          wd.vy = rpw_pkg::sat_add(rdata_q.vy, 34'(fy_q));
          out_load = 1'b1;
          out_nxt.status = rpw_pkg::StForce;
          out_nxt.result_index = 6'(idx_q);
          out_nxt.last = 1'b1;
          state_d = rpw_pkg::S_IDLE;
        end
      end
      rpw_pkg::S_G_MUL: state_d = rpw_pkg::S_G_SAT;
      rpw_pkg::S_G_SAT: begin
        idx_d = '0;
        state_d = (count_q == '0) ? rpw_pkg::S_EMPTY : rpw_pkg::S_B_RD;
      end
      rpw_pkg::S_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt.status = rpw_pkg::StEmpty;
          out_nxt.last = 1'b1;
          state_d = rpw_pkg::S_IDLE;
        end
      end
      rpw_pkg::S_B_RD:  state_d = rpw_pkg::S_B_MUL;
      rpw_pkg::S_B_MUL: state_d = rpw_pkg::S_B_V;
      rpw_pkg::S_B_V:   state_d = rpw_pkg::S_B_P;
      rpw_pkg::S_B_P:
        state_d = (coll_q && idx_q != '0) ? rpw_pkg::S_B_COL : rpw_pkg::S_B_WB;
      rpw_pkg::S_B_COL: state_d = hit_w ? rpw_pkg::S_B_CMUL : rpw_pkg::S_B_WB;
      rpw_pkg::S_B_CMUL:
        state_d = (cur_q.mass == '0 && prev_q.mass == '0) ? rpw_pkg::S_B_APPLY
                                                          : rpw_pkg::S_B_DSTART;
      rpw_pkg::S_B_DSTART: state_d = rpw_pkg::S_B_DWAIT;
      rpw_pkg::S_B_DWAIT: if (done1 && done2) state_d = rpw_pkg::S_B_APPLY;
      rpw_pkg::S_B_APPLY: state_d = rpw_pkg::S_B_WB;
      rpw_pkg::S_B_WB: begin
        if (idx_q != '0) begin
          we = 1'b1;
          wa = idx_q - CW'(1);
          wd = prev_q;
        end
        idx_d = idx_q + CW'(1);
        state_d = (idx_q + CW'(1) < count_q) ? rpw_pkg::S_B_RD : rpw_pkg::S_B_LAST;
      end
      rpw_pkg::S_B_LAST: begin
        we = 1'b1;
        wa = idx_q - CW'(1);
        wd = prev_q;
        idx_d = '0;
        state_d = rpw_pkg::S_E_RD;
      end
      rpw_pkg::S_E_RD: state_d = rpw_pkg::S_E_OUT;
      rpw_pkg::S_E_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt.status = rpw_pkg::StPos;
          out_nxt.result_index = 6'(idx_q);
          out_nxt.out_x = rdata_q.x;
          out_nxt.out_y = rdata_q.y;
          out_nxt.last = (idx_q + CW'(1) == count_q);
          idx_d = idx_q + CW'(1);
          state_d = (idx_q + CW'(1) == count_q) ? rpw_pkg::S_IDLE : rpw_pkg::S_E_RD;
        end
      end
      default: state_d = rpw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpw_pkg::S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) body_mem_q[wa[IW-1:0]] <= wd;
    rdata_q <= body_mem_q[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_nxt;
    if (acc) begin
      fx_q <= in_data_i.force_x;
      fy_q <= in_data_i.force_y;
      dt_q <= in_data_i.delta_time;
    end
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    case (state_q)
      rpw_pkg::S_G_SAT: begin
        gx_q <= rpw_pkg::sat_mul(prod_x_q);
        gy_q <= rpw_pkg::sat_mul(prod_y_q);
      end
      rpw_pkg::S_B_MUL: cur_q <= rdata_q;
      rpw_pkg::S_B_V: begin
        cur_q.vx <= rpw_pkg::sat_add(cur_q.vx, 34'(rpw_pkg::sat_mul(prod_x_q)));
        cur_q.vy <= rpw_pkg::sat_add(cur_q.vy, 34'(rpw_pkg::sat_mul(prod_y_q)));
      end
      rpw_pkg::S_B_P: begin
        cur_q.x <= rpw_pkg::sat_add(cur_q.x, 34'(cur_q.vx));
        cur_q.y <= rpw_pkg::sat_add(cur_q.y, 34'(cur_q.vy));
      end
      rpw_pkg::S_B_COL: begin
        above_q <= (y1 < y2);
        o_q     <= o_w[31:0];
      end
      rpw_pkg::S_B_CMUL: begin
        od1_q  <= 64'(o_q) * 64'(cur_q.mass);
        od2_q  <= 64'(o_q) * 64'(prev_q.mass);
        sum_q  <= {1'b0, cur_q.mass} + {1'b0, prev_q.mass};
        sumz_q <= (cur_q.mass == '0 && prev_q.mass == '0);
      end
      rpw_pkg::S_B_APPLY: begin
        if (above_q) begin
          cur_q.y  <= rpw_pkg::sat_add(cur_q.y, -$signed({2'b0, s1}));
          prev_q.y <= rpw_pkg::sat_add(prev_q.y, $signed({2'b0, s2}));
        end else begin
          prev_q.y <= rpw_pkg::sat_add(prev_q.y, -$signed({2'b0, s1}));
          cur_q.y  <= rpw_pkg::sat_add(cur_q.y, $signed({2'b0, s2}));
        end
      end
      rpw_pkg::S_B_WB: prev_q <= cur_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/testbench.sv =====
// Testbench for rect_physics_world_step_core: transfers checked against a body-table model.
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] KindUnused = 2'd3;

  class world_tracker;
    logic signed [31:0] grav_x, grav_y;
    logic               coll_on;
    logic signed [31:0] bx[64], by[64], bvx[64], bvy[64];
    logic [15:0]        bw[64], bh[64];
    logic [31:0]        bm[64];
    int unsigned        count;
    rpw_pkg::out_item_t pending[$];
    int                 errors;

    function new();
      grav_x  = 0;
      grav_y  = rpw_pkg::GravYReset;
      coll_on = 1'b1;
      count   = 0;
      errors  = 0;
    endfunction

    function logic signed [31:0] clamp(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function logic signed [31:0] fxmul(logic signed [31:0] a, logic [31:0] b);
      longint p;
      p = longint'(a) * longint'({32'b0, b});
      return clamp(p >>> 16);
    endfunction

    function void push(logic [2:0] st, int idx, logic signed [31:0] x,
                       logic signed [31:0] y, logic lst);
      rpw_pkg::out_item_t e;
      e.status       = st;
      e.result_index = idx[5:0];
      e.out_x        = x;
      e.out_y        = y;
      e.last         = lst;
      pending.push_back(e);
    endfunction

    function void collide(int i);
      longint x1, y1, x2, y2, w1, h1, w2, h2, o, s1, s2;
      logic [127:0] sum;
      int j;
      j  = i - 1;
      x1 = bx[i]; y1 = by[i]; x2 = bx[j]; y2 = by[j];
      w1 = longint'(bw[i]) * 65536; h1 = longint'(bh[i]) * 65536;
      w2 = longint'(bw[j]) * 65536; h2 = longint'(bh[j]) * 65536;
      if (!(x1 < x2 + w2 && x1 + w1 > x2 && y1 < y2 + h2 && y1 + h1 > y2)) return;
      if (y1 == y2) return;
      o   = (y1 < y2) ? (y1 + h1 - y2) : (y2 + h2 - y1);
      sum = 128'(bm[i]) + 128'(bm[j]);
      if (sum == 0) begin
        s1 = o >>> 1;
        s2 = o >>> 1;
      end else begin
        s1 = longint'((128'(o) * 128'(bm[i])) / sum);
        s2 = longint'((128'(o) * 128'(bm[j])) / sum);
      end
      if (y1 < y2) begin
        by[i] = clamp(longint'(by[i]) - s1);
        by[j] = clamp(longint'(by[j]) + s2);
      end else begin
        by[j] = clamp(longint'(by[j]) - s1);
        by[i] = clamp(longint'(by[i]) + s2);
      end
    endfunction

    function void note_item(rpw_pkg::in_item_t it);
      logic signed [31:0] gx, gy;
      case (it.kind)
        rpw_pkg::KindAdd: begin
          if (count >= 64) push(rpw_pkg::StFull, 0, 0, 0, 1);
          else begin
            bx[count] = it.pos_x; by[count] = it.pos_y;
            bw[count] = it.width; bh[count] = it.height;
            bm[count] = it.density;
            bvx[count] = 0; bvy[count] = 0;
            push(rpw_pkg::StAdded, count, 0, 0, 1);
            count++;
          end
        end
        rpw_pkg::KindForce: begin
          if (it.body_index >= count) push(rpw_pkg::StBad, it.body_index, 0, 0, 1);
          else begin
            bvx[it.body_index] = clamp(longint'(bvx[it.body_index]) + it.force_x);
            bvy[it.body_index] = clamp(longint'(bvy[it.body_index]) + it.force_y);
            push(rpw_pkg::StForce, it.body_index, 0, 0, 1);
          end
        end
        rpw_pkg::KindStep: begin
          gx = fxmul(grav_x, it.delta_time);
          gy = fxmul(grav_y, it.delta_time);
          if (count == 0) push(rpw_pkg::StEmpty, 0, 0, 0, 1);
          else begin
            for (int i = 0; i < count; i++) begin
              bvx[i] = clamp(longint'(bvx[i]) + fxmul(gx, bm[i]));
              bx[i]  = clamp(longint'(bx[i]) + bvx[i]);
              bvy[i] = clamp(longint'(bvy[i]) + fxmul(gy, bm[i]));
              by[i]  = clamp(longint'(by[i]) + bvy[i]);
              if (coll_on && i > 0) collide(i);
            end
            for (int i = 0; i < count; i++)
              push(rpw_pkg::StPos, i, bx[i], by[i], (i + 1 == count));
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(rpw_pkg::out_item_t got);
      rpw_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, got %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.result_index !== e.result_index ||
          got.out_x !== e.out_x || got.out_y !== e.out_y || got.last !== e.last) begin
        $display("%0t: mismatch expected st=%0d idx=%0d x=%h y=%h last=%b",
                 $realtime, e.status, e.result_index, e.out_x, e.out_y, e.last);
        $display("%0t:          actual   st=%0d idx=%0d x=%h y=%h last=%b",
                 $realtime, got.status, got.result_index, got.out_x, got.out_y, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i, rst_ni;
  logic               in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  rpw_pkg::in_item_t  in_data_i;
  rpw_pkg::out_item_t out_data_o;
  logic               psel, penable, pwrite, pready;
  logic [3:0]         paddr;
  logic [31:0]        pwdata, prdata;
  int                 idle_pct, stall_pct;
  world_tracker       world;

  rect_physics_world_step_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) world.check_result(out_data_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rpw_pkg::RegGravX: world.grav_x = val;
      rpw_pkg::RegGravY: world.grav_y = val;
      default:           world.coll_on = val[0];
    endcase
  endtask

  task automatic send(rpw_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    world.note_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (world.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_q(int span);
    if ($urandom_range(9) == 0) return $urandom;
    return (($urandom_range(2 * span) - span) <<< 16) + $urandom_range(65535);
  endfunction

  function automatic rpw_pkg::in_item_t rand_item();
    rpw_pkg::in_item_t it;
    int r;
    it = rpw_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom});
    r = $urandom_range(99);
    it.kind = (r < 35) ? rpw_pkg::KindAdd : (r < 70) ? rpw_pkg::KindForce :
              (r < 93) ? rpw_pkg::KindStep : KindUnused;
    it.pos_x = pick_q(20);
    it.pos_y = pick_q(20);
    if ($urandom_range(9) != 0) begin
      it.width  = 16'($urandom_range(8));
      it.height = 16'($urandom_range(8));
    end
    r = $urandom_range(9);
    if (r == 0) it.density = '0;
    else if (r > 1) it.density = $urandom_range(4 * 65536);
    it.force_x = pick_q(2);
    it.force_y = pick_q(2);
    if ($urandom_range(9) != 0) it.delta_time = $urandom_range(16384);
    if ($urandom_range(9) != 0) it.body_index = 6'($urandom_range(world.count));
    return it;
  endfunction

  task automatic run_phase(int n, int idle, int stall, bit hold);
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      if (hold && k == n / 2) begin
        in_valid_i <= 1'b0;
        while (world.pending.size() != 0) @(posedge clk_i);
      end
      send(rand_item());
    end
    drain();
  endtask

  initial begin
    rpw_pkg::in_item_t it;
    world = new();
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_pct = 0; stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty world, bad index, unused kind, extremes, collisions
    it = '0; it.kind = rpw_pkg::KindStep; it.delta_time = '1; send(it);
    it = '0; it.kind = rpw_pkg::KindForce; it.body_index = 6'd63; send(it);
    it = '1; it.kind = KindUnused; send(it);
    it = '0; it.kind = rpw_pkg::KindAdd; it.pos_x = 32'sh7fffffff; it.pos_y = 32'sh7fffffff;
    it.width = 16'hffff; it.height = 16'hffff; it.density = '1; send(it);
    it = '0; it.kind = rpw_pkg::KindAdd; it.pos_x = 32'sh80000000; it.pos_y = 32'sh80000000;
    send(it);
    it = '0; it.kind = rpw_pkg::KindAdd; it.width = 4; it.height = 4; send(it);
    it.pos_y = 32'sh00020000; send(it);
    it.pos_y = 32'sh00010000; it.density = 32'h00010000; send(it);
    it.pos_y = 32'sh00038000; it.density = 32'h00030000; send(it);
    it.pos_y = 32'sh00038000; send(it);
    it = '0; it.kind = rpw_pkg::KindForce; it.body_index = 0;
    it.force_x = 32'sh7fffffff; it.force_y = 32'sh7fffffff; send(it);
    it.body_index = 1; it.force_x = 32'sh80000000; it.force_y = 32'sh80000000; send(it);
    it.body_index = 6; send(it);
    it = '0; it.kind = rpw_pkg::KindStep; it.delta_time = 32'h00010000; send(it);
    it.delta_time = 0; send(it);
    it.delta_time = '1; send(it);
    drain();

    run_phase(40, 0, 0, 0);
    reg_write(rpw_pkg::RegGravX, 32'h7fffffff);
    reg_write(rpw_pkg::RegGravY, 32'h80000000);
    reg_write(rpw_pkg::RegColl, 32'd0);
    run_phase(40, 79, 0, 0);
    reg_write(rpw_pkg::RegGravX, 32'h00004000);
    reg_write(rpw_pkg::RegGravY, 32'h00010000);
    reg_write(rpw_pkg::RegColl, 32'd1);
    run_phase(40, 0, 79, 1);
    reg_write(rpw_pkg::RegGravX, 32'h80000000);
    reg_write(rpw_pkg::RegGravY, 32'h7fffffff);
    run_phase(40, 9, 9, 0);

    if (world.errors == 0 && world.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
